[sv/sbc_pkg.sv]
`default_nettype none
package sbc_pkg;

    // Pipeline depths
    localparam int unsigned FRONT_LAT = 5;
    localparam int unsigned SQ_LAT    = 31;
    localparam int unsigned DIV_QB    = 31;
    localparam int unsigned DIV_LAT   = DIV_QB + 1;
    localparam int unsigned TOTAL_LAT = FRONT_LAT + SQ_LAT + DIV_LAT + 1;

    // Q2.14 unit normal components
    localparam logic signed [15:0] NORM_ONE = 16'sd16384;
    localparam logic signed [15:0] NORM_NEG = -16'sd16384;

    localparam logic [31:0]        DEPTH_MAX = 32'hFFFF_FFFF;
    localparam logic signed [34:0] COORD_MAX = 35'sd2147483647;
    localparam logic signed [34:0] COORD_MIN = -35'sd2147483648;

    // One sphere/box pair
    typedef struct packed {
        logic [2:0][31:0] c;
        logic [2:0][31:0] lo;
        logic [2:0][31:0] hi;
        logic [30:0]      r;
        logic             first;
    } t_item;

    // Data that rides alongside the root and the dividers
    typedef struct packed {
        logic [2:0][31:0] c;
        logic [2:0][31:0] cl;
        logic [2:0]       dneg;
        logic             first;
        logic             hit_out;
        logic             in_box;
        logic [2:0][31:0] in_con;
        logic [2:0][15:0] in_nrm;
        logic [31:0]      in_depth;
        logic             in_ovf;
        logic [30:0]      r;
    } t_side;

    typedef struct packed {
        t_side            side;
        logic [2:0][30:0] m;
        logic [2:0][61:0] mr;
    } t_seg_a;

    typedef struct packed {
        t_side       side;
        logic [31:0] odepth;
    } t_seg_b;

    function automatic logic f_out32(input logic signed [34:0] v);
        return (v > COORD_MAX) || (v < COORD_MIN);
    endfunction

    function automatic logic [31:0] f_sat32(input logic signed [34:0] v);
        if (v > COORD_MAX) begin
            return 32'h7FFF_FFFF;
        end else if (v < COORD_MIN) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

[sv/sbc_delay.sv]
`default_nettype none
module sbc_delay #(
    parameter int unsigned W = 1,
    parameter int unsigned N = 1
) (
    input  logic         i_clk,
    input  logic         i_ce,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    logic [W-1:0] r_tap [0:N-1];

    // Shift the side data one stage per advance
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_d = r_tap[N-1];

endmodule
`default_nettype wire

[sv/sbc_sqrt.sv]
`default_nettype none
module sbc_sqrt (
    input  logic                          i_clk,
    input  logic                          i_ce,
    input  logic [2*sbc_pkg::SQ_LAT-1:0]  i_rad,
    output logic [sbc_pkg::SQ_LAT-1:0]    o_root
);
    import sbc_pkg::*;

    logic [2*SQ_LAT-1:0] r_val  [0:SQ_LAT-1];
    logic [32:0]         r_rem  [0:SQ_LAT-1];
    logic [SQ_LAT-1:0]   r_root [0:SQ_LAT-1];

    // One root bit per stage, most significant pair first
    for (genvar j = 0; j < SQ_LAT; j++) begin : g_step
        localparam int P = SQ_LAT - 1 - j;
        logic [2*SQ_LAT-1:0] val_in;
        logic [32:0]         rem_in;
        logic [SQ_LAT-1:0]   root_in;
        logic [34:0]         cur;
        logic [34:0]         trial;

        if (j == 0) begin : g_first
            assign val_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign val_in  = r_val[j-1];
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
        end

        assign cur   = {rem_in, val_in[2*P+1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_val[j] <= val_in;
                if (cur >= trial) begin
                    r_rem[j]  <= 33'(cur - trial);
                    r_root[j] <= {root_in[SQ_LAT-2:0], 1'b1};
                end else begin
                    r_rem[j]  <= cur[32:0];
                    r_root[j] <= {root_in[SQ_LAT-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[SQ_LAT-1];

endmodule
`default_nettype wire

[sv/sbc_div.sv]
`default_nettype none
module sbc_div (
    input  logic                        i_clk,
    input  logic                        i_ce,
    input  logic [61:0]                 i_num,
    input  logic [30:0]                 i_den,
    output logic [sbc_pkg::DIV_QB-1:0]  o_quo
);
    import sbc_pkg::*;

    logic [63:0]       r_rem [0:DIV_QB];
    logic [31:0]       r_den [0:DIV_QB];
    logic [DIV_QB-1:0] r_quo [0:DIV_QB];

    // Round to nearest: divide 2*num + den by 2*den
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0] <= {1'b0, i_num, 1'b0} + {33'b0, i_den};
            r_den[0] <= {i_den, 1'b0};
            r_quo[0] <= '0;
        end
    end

    // One quotient bit per stage
    for (genvar j = 1; j <= DIV_QB; j++) begin : g_step
        localparam int K = DIV_QB - j;
        logic [63:0] trial;

        assign trial = {32'b0, r_den[j-1]} << K;

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_den[j] <= r_den[j-1];
                if (r_rem[j-1] >= trial) begin
                    r_rem[j] <= r_rem[j-1] - trial;
                    r_quo[j] <= r_quo[j-1] | (DIV_QB'(1) << K);
                end else begin
                    r_rem[j] <= r_rem[j-1];
                    r_quo[j] <= r_quo[j-1];
                end
            end
        end
    end

    assign o_quo = r_quo[DIV_QB];

endmodule
`default_nettype wire

[sv/sbc_front.sv]
`default_nettype none
module sbc_front (
    input  logic             i_clk,
    input  logic             i_ce,
    input  sbc_pkg::t_item   i_item,
    output logic [61:0]      o_rad,
    output sbc_pkg::t_seg_a  o_seg
);
    import sbc_pkg::*;

    // Stage 1: capture the beat
    t_item r1;

    // Stage 2: clamp, deltas, face distances
    logic signed [32:0] w_d    [3];
    logic [32:0]        w_absd [3];
    logic [31:0]        w_cl   [3];
    logic [2:0]         w_lt, w_gt, w_far;
    logic [31:0]        w_fd   [6];

    t_item       r2_item;
    logic [31:0] r2_cl   [3];
    logic [32:0] r2_absd [3];
    logic [2:0]  r2_dneg;
    logic        r2_inside, r2_far;
    logic [31:0] r2_fd   [6];

    // Stage 3: squares, products, face pairs
    logic [61:0] w_sq [3];
    logic [61:0] w_mr [3];
    logic [61:0] w_rr;
    logic [31:0] w_pd [3];
    logic [2:0]  w_pi [3];

    t_item       r3_item;
    logic [31:0] r3_cl [3];
    logic [30:0] r3_m  [3];
    logic [2:0]  r3_dneg;
    logic        r3_inside, r3_far;
    logic [61:0] r3_sq [3];
    logic [61:0] r3_mr [3];
    logic [61:0] r3_rr;
    logic [31:0] r3_pd [3];
    logic [2:0]  r3_pi [3];

    // Stage 4: distance sum, hit test, nearest face
    logic [63:0] w_sum;
    logic        w_ohit;
    logic [31:0] w_bd;
    logic [2:0]  w_bi;

    t_item       r4_item;
    logic [31:0] r4_cl [3];
    logic [30:0] r4_m  [3];
    logic [2:0]  r4_dneg;
    logic        r4_inside, r4_ohit;
    logic [63:0] r4_sum;
    logic [61:0] r4_mr [3];
    logic [31:0] r4_bd;
    logic [2:0]  r4_bi;

    // Stage 5: inside-case results
    logic [1:0]         w_axis;
    logic               w_neg;
    logic signed [33:0] w_cs, w_rs, w_ss;
    logic [31:0]        w_bs;
    logic signed [34:0] w_sumf, w_half;
    logic [32:0]        w_dep;
    t_seg_a             w_seg;

    t_seg_a      r5_seg;
    logic [61:0] r5_rad;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_lt[i]   = $signed(r1.c[i]) < $signed(r1.lo[i]);
            w_gt[i]   = $signed(r1.c[i]) > $signed(r1.hi[i]);
            w_cl[i]   = w_lt[i] ? r1.lo[i] : (w_gt[i] ? r1.hi[i] : r1.c[i]);
            w_d[i]    = $signed({r1.c[i][31], r1.c[i]}) - $signed({w_cl[i][31], w_cl[i]});
            w_absd[i] = w_d[i][32] ? 33'(-w_d[i]) : 33'(w_d[i]);
            w_far[i]  = w_absd[i] > {2'b00, r1.r};
            w_fd[2*i]   = r1.hi[i] - r1.c[i];
            w_fd[2*i+1] = r1.c[i] - r1.lo[i];
        end
    end

    always_comb begin
        w_rr = {31'b0, r2_item.r} * {31'b0, r2_item.r};
        for (int i = 0; i < 3; i++) begin
            w_sq[i] = {31'b0, r2_absd[i][30:0]} * {31'b0, r2_absd[i][30:0]};
            w_mr[i] = {31'b0, r2_absd[i][30:0]} * {31'b0, r2_item.r};
            // Keep the earlier face of a pair on a tie
            if (r2_fd[2*i+1] < r2_fd[2*i]) begin
                w_pd[i] = r2_fd[2*i+1];
                w_pi[i] = 3'(2*i+1);
            end else begin
                w_pd[i] = r2_fd[2*i];
                w_pi[i] = 3'(2*i);
            end
        end
    end

    always_comb begin
        w_sum  = {2'b00, r3_sq[0]} + {2'b00, r3_sq[1]} + {2'b00, r3_sq[2]};
        w_ohit = !r3_far && !r3_inside && (w_sum <= {2'b00, r3_rr});
        w_bd   = r3_pd[0];
        w_bi   = r3_pi[0];
        if (r3_pd[1] < w_bd) begin
            w_bd = r3_pd[1];
            w_bi = r3_pi[1];
        end
        if (r3_pd[2] < w_bd) begin
            w_bd = r3_pd[2];
            w_bi = r3_pi[2];
        end
    end

    always_comb begin
        w_axis = r4_bi[2:1];
        w_neg  = r4_bi[0];
        w_cs   = $signed({{2{r4_item.c[w_axis][31]}}, r4_item.c[w_axis]});
        w_rs   = $signed({3'b000, r4_item.r});
        w_ss   = w_neg ? (w_cs - w_rs) : (w_cs + w_rs);
        w_bs   = w_neg ? r4_item.lo[w_axis] : r4_item.hi[w_axis];
        w_sumf = $signed({w_ss[33], w_ss}) + $signed({{3{w_bs[31]}}, w_bs});
        w_half = w_sumf >>> 1;
        w_dep  = {2'b00, r4_item.r} + {1'b0, r4_bd};

        w_seg.side.c       = r4_item.c;
        w_seg.side.dneg    = r4_dneg;
        w_seg.side.first   = r4_item.first;
        w_seg.side.hit_out = r4_ohit;
        w_seg.side.in_box  = r4_inside;
        w_seg.side.r       = r4_item.r;
        w_seg.side.in_depth = w_dep[32] ? DEPTH_MAX : w_dep[31:0];
        w_seg.side.in_ovf   = w_dep[32] | f_out32(w_half);
        for (int i = 0; i < 3; i++) begin
            w_seg.side.cl[i] = r4_cl[i];
            w_seg.m[i]       = r4_m[i];
            w_seg.mr[i]      = r4_mr[i];
            if (2'(i) == w_axis) begin
                w_seg.side.in_con[i] = f_sat32(w_half);
                w_seg.side.in_nrm[i] = (w_neg ^ r4_item.first) ? NORM_NEG : NORM_ONE;
            end else begin
                w_seg.side.in_con[i] = r4_item.c[i];
                w_seg.side.in_nrm[i] = '0;
            end
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1 <= i_item;

            r2_item   <= r1;
            r2_dneg   <= {w_d[2][32], w_d[1][32], w_d[0][32]};
            r2_inside <= ~|(w_lt | w_gt);
            r2_far    <= |w_far;
            for (int i = 0; i < 3; i++) begin
                r2_cl[i]   <= w_cl[i];
                r2_absd[i] <= w_absd[i];
            end
            for (int i = 0; i < 6; i++) begin
                r2_fd[i] <= w_fd[i];
            end

            r3_item   <= r2_item;
            r3_dneg   <= r2_dneg;
            r3_inside <= r2_inside;
            r3_far    <= r2_far;
            r3_rr     <= w_rr;
            for (int i = 0; i < 3; i++) begin
                r3_cl[i] <= r2_cl[i];
                r3_m[i]  <= r2_absd[i][30:0];
                r3_sq[i] <= w_sq[i];
                r3_mr[i] <= w_mr[i];
                r3_pd[i] <= w_pd[i];
                r3_pi[i] <= w_pi[i];
            end

            r4_item   <= r3_item;
            r4_dneg   <= r3_dneg;
            r4_inside <= r3_inside;
            r4_ohit   <= w_ohit;
            r4_sum    <= w_sum;
            r4_bd     <= w_bd;
            r4_bi     <= w_bi;
            for (int i = 0; i < 3; i++) begin
                r4_cl[i] <= r3_cl[i];
                r4_m[i]  <= r3_m[i];
                r4_mr[i] <= r3_mr[i];
            end

            r5_seg <= w_seg;
            r5_rad <= r4_sum[61:0];
        end
    end

    assign o_rad = r5_rad;
    assign o_seg = r5_seg;

endmodule
`default_nettype wire

[sv/sphere_box_contact_top.sv]
// Sphere against axis-aligned box contact generation, one pair per beat.
// A pair is accepted every cycle unless the pipeline holds, and its result
// passes 5 front stages (clamp, squares, face search), a 31-stage square root,
// a 32-stage rounding divider bank (normal and offset per axis) and the output
// register. The whole pipeline holds while an output beat waits unaccepted,
// so input ready follows output ready in the same cycle.
`default_nettype none
module sphere_box_contact_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // c_x, c_y, c_z, radius(31), min_x, min_y, min_z, max_x, max_y, max_z, pad(1)
    input  logic [319:0] i_s_tdata,
    // sphere_is_first
    input  logic [0:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // contact_x, contact_y, contact_z, normal_x, normal_y, normal_z, depth
    output logic [175:0] o_m_tdata,
    // hit, overflow
    output logic [1:0]   o_m_tuser
);
    import sbc_pkg::*;

    logic                 w_ce;
    t_item                w_item;
    logic [61:0]          w_rad;
    t_seg_a               w_seg_a, w_seg_a_d;
    t_seg_b               w_seg_b, w_seg_b_d;
    logic [SQ_LAT-1:0]    w_root;
    logic [DIV_QB-1:0]    w_qn [3];
    logic [DIV_QB-1:0]    w_qo [3];

    logic [TOTAL_LAT-1:0] r_vld;

    logic signed [33:0]   w_c34 [3];
    logic signed [33:0]   w_off [3];
    logic signed [33:0]   w_ss  [3];
    logic signed [34:0]   w_sm  [3];
    logic [31:0]          w_con [3];
    logic [15:0]          w_nrm [3];
    logic [31:0]          w_dep;
    logic                 w_hit, w_ovf;

    logic [31:0]          r_con [3];
    logic [15:0]          r_nrm [3];
    logic [31:0]          r_dep;
    logic                 r_hit, r_ovf;

    // Advance whenever the output slot is free or being taken
    assign w_ce       = !r_vld[TOTAL_LAT-1] || i_m_tready;
    assign o_s_tready = w_ce;

    // Unpack the input beat
    always_comb begin
        w_item.c[0]  = i_s_tdata[31:0];
        w_item.c[1]  = i_s_tdata[63:32];
        w_item.c[2]  = i_s_tdata[95:64];
        w_item.r     = i_s_tdata[126:96];
        w_item.lo[0] = i_s_tdata[158:127];
        w_item.lo[1] = i_s_tdata[190:159];
        w_item.lo[2] = i_s_tdata[222:191];
        w_item.hi[0] = i_s_tdata[254:223];
        w_item.hi[1] = i_s_tdata[286:255];
        w_item.hi[2] = i_s_tdata[318:287];
        w_item.first = i_s_tuser[0];
    end

    sbc_front u_front (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_item (w_item),
        .o_rad  (w_rad),
        .o_seg  (w_seg_a)
    );

    sbc_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_rad  (w_rad),
        .o_root (w_root)
    );

    sbc_delay #(.W($bits(t_seg_a)), .N(SQ_LAT)) u_dly_a (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_d   (w_seg_a),
        .o_d   (w_seg_a_d)
    );

    // Depth for the outside case once the distance is known
    assign w_seg_b.side   = w_seg_a_d.side;
    assign w_seg_b.odepth = {1'b0, w_seg_a_d.side.r} - {1'b0, w_root};

    for (genvar i = 0; i < 3; i++) begin : g_axis
        sbc_div u_div_n (
            .i_clk (i_clk),
            .i_ce  (w_ce),
            .i_num ({17'b0, w_seg_a_d.m[i], 14'b0}),
            .i_den (w_root),
            .o_quo (w_qn[i])
        );
        sbc_div u_div_o (
            .i_clk (i_clk),
            .i_ce  (w_ce),
            .i_num (w_seg_a_d.mr[i]),
            .i_den (w_root),
            .o_quo (w_qo[i])
        );
    end

    sbc_delay #(.W($bits(t_seg_b)), .N(DIV_LAT)) u_dly_b (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_d   (w_seg_b),
        .o_d   (w_seg_b_d)
    );

    // Pick inside or outside results, zero on a miss
    always_comb begin
        w_hit = 1'b0;
        w_ovf = 1'b0;
        w_dep = '0;
        for (int i = 0; i < 3; i++) begin
            w_c34[i] = $signed({{2{w_seg_b_d.side.c[i][31]}}, w_seg_b_d.side.c[i]});
            w_off[i] = $signed({3'b000, w_qo[i]});
            w_ss[i]  = w_seg_b_d.side.dneg[i] ? (w_c34[i] + w_off[i]) : (w_c34[i] - w_off[i]);
            w_sm[i]  = ($signed({w_ss[i][33], w_ss[i]})
                        + $signed({{3{w_seg_b_d.side.cl[i][31]}}, w_seg_b_d.side.cl[i]})) >>> 1;
            w_con[i] = '0;
            w_nrm[i] = '0;
        end
        if (w_seg_b_d.side.in_box) begin
            w_hit = 1'b1;
            w_ovf = w_seg_b_d.side.in_ovf;
            w_dep = w_seg_b_d.side.in_depth;
            for (int i = 0; i < 3; i++) begin
                w_con[i] = w_seg_b_d.side.in_con[i];
                w_nrm[i] = w_seg_b_d.side.in_nrm[i];
            end
        end else if (w_seg_b_d.side.hit_out) begin
            w_hit = 1'b1;
            w_dep = w_seg_b_d.odepth;
            for (int i = 0; i < 3; i++) begin
                w_con[i] = f_sat32(w_sm[i]);
                w_ovf    = w_ovf | f_out32(w_sm[i]);
                w_nrm[i] = (w_seg_b_d.side.dneg[i] ^ w_seg_b_d.side.first)
                         ? 16'(-w_qn[i][15:0]) : w_qn[i][15:0];
            end
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], i_s_tvalid};
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_hit <= w_hit;
            r_ovf <= w_ovf;
            r_dep <= w_dep;
            for (int i = 0; i < 3; i++) begin
                r_con[i] <= w_con[i];
                r_nrm[i] <= w_nrm[i];
            end
        end
    end

    assign o_m_tvalid = r_vld[TOTAL_LAT-1];
    assign o_m_tdata  = {r_dep, r_nrm[2], r_nrm[1], r_nrm[0], r_con[2], r_con[1], r_con[0]};
    assign o_m_tuser  = {r_ovf, r_hit};

endmodule
`default_nettype wire

[sv/sbc_checker.sv]
`default_nettype none
module sbc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [319:0] i_s_tdata,
    input logic [0:0]   i_s_tuser,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [175:0] o_m_tdata,
    input logic [1:0]   o_m_tuser
);

    // Output valid drops after reset
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // Input side advances exactly when the output slot frees
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not track output slot");

    // Stalled output beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled output beat changed");

    // A miss carries an all-zero result
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> (o_m_tdata == '0) && !o_m_tuser[1])
        else $error("miss with nonzero payload");

    // Normal components stay within unit range
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            ($signed(o_m_tdata[111:96])  <= 16'sd16384) && ($signed(o_m_tdata[111:96])  >= -16'sd16384) &&
            ($signed(o_m_tdata[127:112]) <= 16'sd16384) && ($signed(o_m_tdata[127:112]) >= -16'sd16384) &&
            ($signed(o_m_tdata[143:128]) <= 16'sd16384) && ($signed(o_m_tdata[143:128]) >= -16'sd16384))
        else $error("normal component out of range");

endmodule

bind sphere_box_contact_top sbc_checker u_sbc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire
